// ----- rtl/core/c2e_pkg.sv -----
// Shared types, constants and calendar functions for the calendar to epoch seconds converter.
package c2e_pkg;

  localparam int unsigned DAYS_W = 17;
  localparam int unsigned SECS_W = 32;

  localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = DAYS_W'(365);
  localparam logic [SECS_W-1:0] SEC_PER_DAY   = SECS_W'(86400);
  localparam logic [SECS_W-1:0] SEC_PER_HOUR  = SECS_W'(3600);
  localparam logic [SECS_W-1:0] SEC_PER_MIN   = SECS_W'(60);
  localparam logic [3:0]        MONTHS        = 4'd12;
  localparam logic [3:0]        FEB_IDX       = 4'd1;
  localparam logic [4:0]        FEB_LEAP_DAYS = 5'd29;

  // year offsets of 2100 and 2200: divisible by 4 but not leap
  localparam logic [7:0] OFF_2100 = 8'd130;
  localparam logic [7:0] OFF_2200 = 8'd230;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_YEAR  = 5'b00010,
    ST_MONTH = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic yr_step;
    logic mo_clr;
    logic mo_step;
    logic mul;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic yr_done;
    logic mo_done;
  } sts_t;

  // 1970 + off divisible by 4 <=> (off + 2) mod 4 == 0
  function automatic logic is_leap(input logic [7:0] off);
    logic [1:0] m4;
    m4 = off[1:0] + 2'd2;
    return (m4 == 2'd0) && (off != OFF_2100) && (off != OFF_2200);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] k);
    logic [4:0] d;
    case (k)
      4'd0:    d = 5'd31;
      4'd1:    d = 5'd28;
      4'd2:    d = 5'd31;
      4'd3:    d = 5'd30;
      4'd4:    d = 5'd31;
      4'd5:    d = 5'd30;
      4'd6:    d = 5'd31;
      4'd7:    d = 5'd31;
      4'd8:    d = 5'd30;
      4'd9:    d = 5'd31;
      4'd10:   d = 5'd30;
      4'd11:   d = 5'd31;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/core/calendar_to_epoch_seconds.sv -----
// Top level: calendar date and time to seconds since 1970-01-01 00:00:00.
//
//   channel  handshake             payload
//   input    start & !busy         in_year_offset, in_month, in_day, in_hour,
//                                  in_minute, in_second
//   result   out_valid (1 cycle)   out_epoch_seconds
//
// A transaction runs the year loop (one year per cycle, then an exit step that
// clears the counter), the month loop (one month per cycle, then an exit step),
// then a scale step and a final sum step, and ends with out_valid.
// One transaction at a time; busy is high while it runs.
// Synchronous active-low reset returns the sequencer to idle and drops out_valid.
// The result strobe cannot be stalled.
module calendar_to_epoch_seconds import c2e_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        in_year_offset,
  input  logic [3:0]        in_month,
  input  logic [4:0]        in_day,
  input  logic [4:0]        in_hour,
  input  logic [5:0]        in_minute,
  input  logic [5:0]        in_second,
  output logic              out_valid,
  output logic [SECS_W-1:0] out_epoch_seconds
);

  cmd_t cmd;
  sts_t sts;

  c2e_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  c2e_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_year_offset    (in_year_offset),
    .in_month          (in_month),
    .in_day            (in_day),
    .in_hour           (in_hour),
    .in_minute         (in_minute),
    .in_second         (in_second),
    .out_valid         (out_valid),
    .out_epoch_seconds (out_epoch_seconds)
  );

endmodule

// ----- rtl/core/c2e_ctrl.sv -----
// Sequencer for the converter: year loop, month loop, scale and final sum.
module c2e_ctrl import c2e_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (sts.yr_done) begin
          cmd.mo_clr = 1'b1;
          state_nxt  = ST_MONTH;
        end else begin
          cmd.yr_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (sts.mo_done) begin
          state_nxt = ST_MUL;
        end else begin
          cmd.mo_step = 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- rtl/core/c2e_dp.sv -----
// Datapath: operand registers, day accumulator, loop counter, scaling and result register.
module c2e_dp import c2e_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [7:0]        in_year_offset,
  input  logic [3:0]        in_month,
  input  logic [4:0]        in_day,
  input  logic [4:0]        in_hour,
  input  logic [5:0]        in_minute,
  input  logic [5:0]        in_second,
  output logic              out_valid,
  output logic [SECS_W-1:0] out_epoch_seconds
);

  logic [7:0]        yoff_r;
  logic [3:0]        elapsed_r;
  logic [4:0]        day_r;
  logic [4:0]        hour_r;
  logic [5:0]        minute_r;
  logic [5:0]        second_r;
  logic [7:0]        cnt_r;
  logic [DAYS_W-1:0] days_r;
  logic [SECS_W-1:0] prod_r;
  logic [SECS_W-1:0] res_r;
  logic              valid_r;

  logic [3:0]        elapsed_nxt;
  logic [4:0]        mlen;
  logic [DAYS_W-1:0] days_tot;
  logic [SECS_W-1:0] sum_nxt;

  always_comb begin
    if (in_month == 4'd0) begin
      elapsed_nxt = 4'd0;
    end else if (in_month > MONTHS) begin
      elapsed_nxt = MONTHS;
    end else begin
      elapsed_nxt = in_month - 4'd1;
    end
  end

  always_comb begin
    if ((cnt_r[3:0] == FEB_IDX) && is_leap(yoff_r)) begin
      mlen = FEB_LEAP_DAYS;
    end else begin
      mlen = month_days(cnt_r[3:0]);
    end
  end

  assign days_tot = days_r + DAYS_W'(day_r);

  assign sum_nxt = prod_r
                 + SECS_W'(hour_r) * SEC_PER_HOUR
                 + SECS_W'(minute_r) * SEC_PER_MIN
                 + SECS_W'(second_r)
                 - SEC_PER_DAY;

  assign sts.yr_done = (cnt_r == yoff_r);
  assign sts.mo_done = (cnt_r[3:0] == elapsed_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      yoff_r    <= in_year_offset;
      elapsed_r <= elapsed_nxt;
      day_r     <= in_day;
      hour_r    <= in_hour;
      minute_r  <= in_minute;
      second_r  <= in_second;
      cnt_r     <= '0;
      days_r    <= '0;
    end else if (cmd.yr_step) begin
      days_r <= days_r + DAYS_PER_YEAR + DAYS_W'(is_leap(cnt_r));
      cnt_r  <= cnt_r + 8'd1;
    end else if (cmd.mo_clr) begin
      cnt_r <= '0;
    end else if (cmd.mo_step) begin
      days_r <= days_r + DAYS_W'(mlen);
      cnt_r  <= cnt_r + 8'd1;
    end
    if (cmd.mul) begin
      prod_r <= SECS_W'(days_tot) * SEC_PER_DAY;
    end
    if (cmd.fin) begin
      res_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.fin;
    end
  end

  assign out_valid         = valid_r;
  assign out_epoch_seconds = res_r;

endmodule
